>>> rtl/core/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 10;
    localparam int BITS_W = 4;

    localparam int RESET_LOW_TICKS_DEF = 480;

    // Bus timing in microsecond ticks.
    localparam logic [CNT_W-1:0] T_PRES_SAMPLE = CNT_W'(70);
    localparam logic [CNT_W-1:0] T_RST_REC     = CNT_W'(410);
    localparam logic [CNT_W-1:0] T_SHORT_LOW   = CNT_W'(6);
    localparam logic [CNT_W-1:0] T_W0_LOW      = CNT_W'(60);
    localparam logic [CNT_W-1:0] T_W1_REC      = CNT_W'(64);
    localparam logic [CNT_W-1:0] T_W0_REC      = CNT_W'(10);
    localparam logic [CNT_W-1:0] T_RD_SAMPLE   = CNT_W'(9);
    localparam logic [CNT_W-1:0] T_RD_REC      = CNT_W'(55);

    localparam logic [BITS_W-1:0] BITS_BYTE = BITS_W'(8);

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_TICK  = 3'd0;
    localparam t_op OP_RESET = 3'd1;
    localparam t_op OP_WBIT  = 3'd2;
    localparam t_op OP_RBIT  = 3'd3;
    localparam t_op OP_WBYTE = 3'd4;
    localparam t_op OP_RBYTE = 3'd5;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [DATA_W-1:0] read_data;
        logic              rejected;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/owbm_in_if.sv
`default_nettype none

interface owbm_in_if import owbm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_value;
    logic              line_level;

    modport source (output valid, output op, output data_value, output line_level,
                    input ready);
    modport sink   (input valid, input op, input data_value, input line_level,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/owbm_out_if.sv
`default_nettype none

interface owbm_out_if import owbm_pkg::*;;
    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [DATA_W-1:0] read_data;
    logic              rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, input rejected,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/owbm_seq.sv
`default_nettype none

module owbm_seq import owbm_pkg::*; #(
    parameter int RESET_LOW_TICKS = RESET_LOW_TICKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DATA_W-1:0] i_data_value,
    input  wire logic              i_line_level,
    output t_result                o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_SLOT_LOW,
        PH_RD_WAIT,
        PH_SLOT_REC
    } t_phase;

    localparam logic [CNT_W-1:0] T_RST_LOW = CNT_W'(RESET_LOW_TICKS);

    t_phase             r_phase, n_phase;
    t_op                r_kind, n_kind;
    logic [CNT_W-1:0]   r_tick, n_tick;
    logic [DATA_W-1:0]  r_shift, n_shift;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic               r_presence, n_presence;
    logic               r_line, n_line;

    logic               done;
    logic               rej;
    logic               is_read;
    logic               one;
    logic [CNT_W-1:0]   cnt;
    logic [DATA_W-1:0]  rd;

    assign is_read = (r_kind == OP_RBIT) || (r_kind == OP_RBYTE);
    assign one     = r_shift[0];
    assign cnt     = r_tick + CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_tick     = r_tick;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_presence = r_presence;
        n_line     = r_line;
        done       = 1'b0;
        rej        = 1'b0;
        rd         = '0;

        case (i_op)
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_tick = cnt;
                    case (r_phase)
                        PH_RST_LOW: begin
                            if (cnt >= T_RST_LOW) begin
                                n_line  = 1'b0;
                                n_tick  = '0;
                                n_phase = PH_RST_WAIT;
                            end
                        end
                        PH_RST_WAIT: begin
                            if (cnt >= T_PRES_SAMPLE) begin
                                n_presence = ~i_line_level;
                                n_tick     = '0;
                                n_phase    = PH_RST_REC;
                            end
                        end
                        PH_RST_REC: begin
                            if (cnt >= T_RST_REC) begin
                                n_line  = 1'b0;
                                n_tick  = '0;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                        PH_SLOT_LOW: begin
                            if (cnt >= (is_read ? T_SHORT_LOW
                                                : (one ? T_SHORT_LOW : T_W0_LOW))) begin
                                n_line  = 1'b0;
                                n_tick  = '0;
                                n_phase = is_read ? PH_RD_WAIT : PH_SLOT_REC;
                            end
                        end
                        PH_RD_WAIT: begin
                            if (cnt >= T_RD_SAMPLE) begin
                                if (r_kind == OP_RBIT) begin
                                    n_shift = {{(DATA_W-1){1'b0}}, i_line_level};
                                end else begin
                                    n_shift = {i_line_level, r_shift[DATA_W-1:1]};
                                end
                                n_tick  = '0;
                                n_phase = PH_SLOT_REC;
                            end
                        end
                        PH_SLOT_REC: begin
                            if (cnt >= (is_read ? T_RD_REC
                                                : (one ? T_W1_REC : T_W0_REC))) begin
                                if (!is_read) begin
                                    n_shift = {1'b0, r_shift[DATA_W-1:1]};
                                end
                                n_tick = '0;
                                if (r_bits > BITS_W'(1)) begin
                                    // Next bit slot of a byte starts on this same tick.
                                    n_bits  = r_bits - BITS_W'(1);
                                    n_line  = 1'b1;
                                    n_phase = PH_SLOT_LOW;
                                end else begin
                                    n_bits  = '0;
                                    n_line  = 1'b0;
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                    if (is_read) begin
                                        rd = n_shift;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_line  = 1'b0;
                            n_tick  = '0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            OP_RESET, OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_kind  = i_op;
                    n_line  = 1'b1;
                    n_tick  = '0;
                    n_phase = PH_SLOT_LOW;
                    case (i_op)
                        OP_RESET: begin
                            n_bits  = '0;
                            n_phase = PH_RST_LOW;
                        end
                        OP_WBIT: begin
                            n_shift = {{(DATA_W-1){1'b0}}, i_data_value[0]};
                            n_bits  = BITS_W'(1);
                        end
                        OP_RBIT: begin
                            n_shift = '0;
                            n_bits  = BITS_W'(1);
                        end
                        OP_WBYTE: begin
                            n_shift = i_data_value;
                            n_bits  = BITS_BYTE;
                        end
                        default: begin
                            n_shift = '0;
                            n_bits  = BITS_BYTE;
                        end
                    endcase
                end
            end
            default: begin
                // Unused codes: no tick, no command.
            end
        endcase
    end

    always_comb begin
        o_res.drive_low = n_line;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = done;
        o_res.presence  = n_presence;
        o_res.read_data = rd;
        o_res.rejected  = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_kind     <= OP_TICK;
            r_tick     <= '0;
            r_shift    <= '0;
            r_bits     <= '0;
            r_presence <= 1'b0;
            r_line     <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_tick     <= n_tick;
            r_shift    <= n_shift;
            r_bits     <= n_bits;
            r_presence <= n_presence;
            r_line     <= n_line;
        end
    end

    a_done_rej_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !(done && rej))
        else $error("done and rejected in the same transaction");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && done) |=> (r_phase == PH_IDLE && !r_line))
        else $error("command completed but sequencer not idle");

    a_rej_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && rej) |=> ($stable(r_phase) && $stable(r_tick) && $stable(r_shift)))
        else $error("rejected command changed sequencer state");

    a_line_low_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line |-> (r_phase == PH_RST_LOW || r_phase == PH_SLOT_LOW))
        else $error("line driven outside a low phase");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BITS_BYTE)
        else $error("bit count out of range");

endmodule

`default_nettype wire

>>> rtl/core/owbm_out_reg.sv
`default_nettype none

module owbm_out_reg import owbm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    // A new result may load while the held one leaves in the same cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res)))
        else $error("held result lost under stall");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid)
        else $error("accepted transaction did not load the result register");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_valid && r_valid && i_ready) |=> !r_valid)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire

>>> rtl/core/onewire_bus_master_unit.sv
`default_nettype none

// Channel  Dir  Fields                                              Handshake
// i_cmd    in   op, data_value, line_level                          valid/ready
// o_res    out  drive_low, busy_res, done_res, presence,            valid/ready
//               read_data, rejected
//
// Every transaction on i_cmd yields one transaction on o_res, registered and presented in the next cycle.
// One transaction per cycle is taken while i_cmd.ready is high; the single sequencer update sets that rate.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, line released.
// i_cmd.ready is low only while a result is held and o_res.ready is low.

module onewire_bus_master_unit import owbm_pkg::*; #(
    parameter int RESET_LOW_TICKS = RESET_LOW_TICKS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    owbm_in_if.sink    i_cmd,
    owbm_out_if.source o_res
);

    t_result seq_res;
    t_result out_res;
    logic    in_ready;
    logic    accept;

    assign i_cmd.ready = in_ready;
    assign accept      = i_cmd.valid && in_ready;

    owbm_seq #(
        .RESET_LOW_TICKS (RESET_LOW_TICKS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_cmd.op),
        .i_data_value (i_cmd.data_value),
        .i_line_level (i_cmd.line_level),
        .o_res        (seq_res)
    );

    owbm_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_res   (seq_res),
        .o_ready (in_ready),
        .o_valid (o_res.valid),
        .o_res   (out_res),
        .i_ready (o_res.ready)
    );

    assign o_res.drive_low = out_res.drive_low;
    assign o_res.busy_res  = out_res.busy_res;
    assign o_res.done_res  = out_res.done_res;
    assign o_res.presence  = out_res.presence;
    assign o_res.read_data = out_res.read_data;
    assign o_res.rejected  = out_res.rejected;

endmodule

`default_nettype wire

>>> tb/onewire_bus_checker.sv
module onewire_bus_checker import owbm_pkg::*; #(
    parameter int RESET_LOW_TICKS = RESET_LOW_TICKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    owbm_in_if   i_cmd,
    owbm_out_if  i_res,
    output int   o_failures,
    output int   o_results_due
);

    typedef enum logic [3:0] {
        BUS_IDLE,
        RST_LOW,
        RST_WAIT,
        RST_RECOVER,
        SLOT_LOW,
        READ_WAIT,
        SLOT_RECOVER
    } bus_phase_e;

    // Shadow copy of the sequencer.
    bus_phase_e        phase;
    t_op               cmd_kind;
    logic [CNT_W-1:0]  ticks;
    logic [DATA_W-1:0] shreg;
    logic [BITS_W-1:0] slots_left;
    logic              pres;
    logic              pull_low;

    t_result bus_results_due[$];
    int      failures;

    assign o_failures = failures;

    function automatic logic is_read_cmd();
        return (cmd_kind == OP_RBIT) || (cmd_kind == OP_RBYTE);
    endfunction

    function automatic void start_slot();
        pull_low = 1'b1;
        ticks    = '0;
        phase    = SLOT_LOW;
    endfunction

    function automatic void go_idle();
        pull_low = 1'b0;
        ticks    = '0;
        phase    = BUS_IDLE;
    endfunction

    // One microsecond of bus time; returns 1 when the command completes.
    function automatic logic advance_tick(logic level);
        logic [CNT_W-1:0] lim;
        logic             bit_one;
        logic             done;
        bit_one = shreg[0];
        done    = 1'b0;
        ticks   = ticks + 1'b1;
        case (phase)
            RST_LOW: begin
                if (ticks >= CNT_W'(RESET_LOW_TICKS)) begin
                    pull_low = 1'b0;
                    ticks    = '0;
                    phase    = RST_WAIT;
                end
            end
            RST_WAIT: begin
                if (ticks >= T_PRES_SAMPLE) begin
                    pres  = ~level;
                    ticks = '0;
                    phase = RST_RECOVER;
                end
            end
            RST_RECOVER: begin
                if (ticks >= T_RST_REC) begin
                    go_idle();
                    done = 1'b1;
                end
            end
            SLOT_LOW: begin
                lim = is_read_cmd() ? T_SHORT_LOW : (bit_one ? T_SHORT_LOW : T_W0_LOW);
                if (ticks >= lim) begin
                    pull_low = 1'b0;
                    ticks    = '0;
                    phase    = is_read_cmd() ? READ_WAIT : SLOT_RECOVER;
                end
            end
            READ_WAIT: begin
                if (ticks >= T_RD_SAMPLE) begin
                    if (cmd_kind == OP_RBIT) begin
                        shreg = {{(DATA_W-1){1'b0}}, level};
                    end else begin
                        shreg = {level, shreg[DATA_W-1:1]};
                    end
                    ticks = '0;
                    phase = SLOT_RECOVER;
                end
            end
            SLOT_RECOVER: begin
                lim = is_read_cmd() ? T_RD_REC : (bit_one ? T_W1_REC : T_W0_REC);
                if (ticks >= lim) begin
                    if (!is_read_cmd()) begin
                        shreg = shreg >> 1;
                    end
                    // A byte starts its next slot on the tick that ends this one.
                    if (slots_left > 1) begin
                        slots_left = slots_left - 1'b1;
                        start_slot();
                    end else begin
                        slots_left = '0;
                        go_idle();
                        done = 1'b1;
                    end
                end
            end
            default: go_idle();
        endcase
        return done;
    endfunction

    function automatic t_result predict_bus_result(t_op op, logic [DATA_W-1:0] data,
                                                   logic level);
        t_result r;
        logic    done;
        logic    rej;
        r    = '0;
        done = 1'b0;
        rej  = 1'b0;
        if (op == OP_TICK) begin
            if (phase != BUS_IDLE) begin
                done = advance_tick(level);
                if (done && is_read_cmd()) begin
                    r.read_data = shreg;
                end
            end
        end else if (op <= OP_RBYTE) begin
            if (phase != BUS_IDLE) begin
                rej = 1'b1;
            end else begin
                cmd_kind = op;
                case (op)
                    OP_RESET: begin
                        pull_low   = 1'b1;
                        ticks      = '0;
                        slots_left = '0;
                        phase      = RST_LOW;
                    end
                    OP_WBIT: begin
                        shreg      = {{(DATA_W-1){1'b0}}, data[0]};
                        slots_left = BITS_W'(1);
                        start_slot();
                    end
                    OP_RBIT: begin
                        shreg      = '0;
                        slots_left = BITS_W'(1);
                        start_slot();
                    end
                    OP_WBYTE: begin
                        shreg      = data;
                        slots_left = BITS_BYTE;
                        start_slot();
                    end
                    default: begin
                        shreg      = '0;
                        slots_left = BITS_BYTE;
                        start_slot();
                    end
                endcase
            end
        end
        r.drive_low = pull_low;
        r.busy_res  = (phase != BUS_IDLE);
        r.done_res  = done;
        r.presence  = pres;
        r.rejected  = rej;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        failures++;
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got,
                               logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    initial begin
        failures = 0;
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase      = BUS_IDLE;
            cmd_kind   = OP_TICK;
            ticks      = '0;
            shreg      = '0;
            slots_left = '0;
            pres       = 1'b0;
            pull_low   = 1'b0;
            bus_results_due.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                bus_results_due.push_back(
                    predict_bus_result(i_cmd.op, i_cmd.data_value, i_cmd.line_level));
            end
            if (i_res.valid && i_res.ready) begin
                got.drive_low = i_res.drive_low;
                got.busy_res  = i_res.busy_res;
                got.done_res  = i_res.done_res;
                got.presence  = i_res.presence;
                got.read_data = i_res.read_data;
                got.rejected  = i_res.rejected;
                if (bus_results_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", got.read_data, '0);
                end else begin
                    want = bus_results_due.pop_front();
                    check_field("drive_low", got.drive_low, want.drive_low);
                    check_field("busy_res", got.busy_res, want.busy_res);
                    check_field("done_res", got.done_res, want.done_res);
                    check_field("presence", got.presence, want.presence);
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("rejected", got.rejected, want.rejected);
                end
            end
        end
        o_results_due <= bus_results_due.size();
    end

endmodule

>>> tb/tb_onewire_bus_master_unit.sv
module tb_onewire_bus_master_unit;
    import owbm_pkg::*;

    localparam t_op OP_NOP6 = 3'd6;
    localparam t_op OP_NOP7 = 3'd7;

    localparam int LINE_RANDOM = 0;
    localparam int LINE_LOW    = 1;
    localparam int LINE_HIGH   = 2;

    localparam int TOTAL_ITEMS      = 1900;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_AT     = 3000;
    localparam int LONG_HOLD_CYCLES = 400;

    localparam int SLOT_TICKS  = int'(T_SHORT_LOW) + int'(T_RD_SAMPLE) + int'(T_RD_REC);
    localparam int RESET_TICKS = RESET_LOW_TICKS_DEF + int'(T_PRES_SAMPLE)
                                 + int'(T_RST_REC);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int failures;
    int results_due;
    int cycle_count = 0;
    int stall_left  = 0;
    int items_sent  = 0;
    bit sender_steady = 1'b0;

    owbm_in_if  cmd_if ();
    owbm_out_if res_if ();

    onewire_bus_master_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    onewire_bus_checker bus_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_if),
        .i_res         (res_if),
        .o_failures    (failures),
        .o_results_due (results_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, a quiet window whenever cycle_count[9:8] is 01, and one
    // long hold-off so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (cycle_count == LONG_HOLD_AT) begin
            res_if.ready <= 1'b0;
            stall_left   <= LONG_HOLD_CYCLES;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (cycle_count[9:8] == 2'b01 || $urandom_range(0, 99) < 75) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= 1'b0;
            stall_left   <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
        end
    end

    function automatic logic line_for(int mode);
        if (mode == LINE_LOW) begin
            return 1'b0;
        end else if (mode == LINE_HIGH) begin
            return 1'b1;
        end
        return 1'($urandom);
    endfunction

    // Offers one transaction and returns once it is taken, after an optional gap.
    task automatic send_item(t_op op, logic [DATA_W-1:0] data, logic level);
        int r;
        int gap;
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.data_value <= data;
        cmd_if.line_level <= level;
        do @(posedge i_clk); while (!cmd_if.ready);
        items_sent++;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!sender_steady) begin
            if (r >= 95) begin
                gap = $urandom_range(8, 30);
            end else if (r >= 70) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A command followed by the ticks that carry it to completion. Noise puts
    // commands (rejected while busy) and unused op codes among the ticks; a
    // cut-short sequence leaves the bus busy for whatever comes next. The
    // tick count never exceeds max_ticks, which keeps the run near its size.
    task automatic run_sequence(t_op op, logic [DATA_W-1:0] data, int mode,
                                int noise_pct, bit cut_short, int max_ticks);
        int ticks_left;
        if (op == OP_RESET) begin
            ticks_left = RESET_TICKS;
        end else if (op == OP_WBYTE || op == OP_RBYTE) begin
            ticks_left = 8 * SLOT_TICKS;
        end else begin
            ticks_left = SLOT_TICKS;
        end
        if (cut_short) begin
            ticks_left = $urandom_range(0, ticks_left);
        end
        if (ticks_left > max_ticks) begin
            ticks_left = max_ticks;
        end
        send_item(op, data, line_for(mode));
        while (ticks_left > 0) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(t_op'($urandom_range(OP_RESET, OP_NOP7)), 8'($urandom),
                          line_for(mode));
            end else begin
                send_item(OP_TICK, 8'($urandom), line_for(mode));
                ticks_left--;
            end
        end
    endtask

    initial begin
        int  r;
        t_op op;
        cmd_if.valid      <= 1'b0;
        cmd_if.op         <= OP_TICK;
        cmd_if.data_value <= '0;
        cmd_if.line_level <= 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks and the unused op codes change nothing.
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_NOP6, 8'hFF, 1'b1);
        send_item(OP_NOP7, 8'h00, 1'b0);
        // Reset with a device answering, then the four single slots.
        run_sequence(OP_RESET, 8'h00, LINE_LOW, 0, 1'b0, RESET_TICKS);
        run_sequence(OP_WBIT, 8'hFF, LINE_HIGH, 0, 1'b0, RESET_TICKS);
        run_sequence(OP_WBIT, 8'h00, LINE_LOW, 0, 1'b0, RESET_TICKS);
        run_sequence(OP_RBIT, 8'h55, LINE_HIGH, 0, 1'b0, RESET_TICKS);
        run_sequence(OP_RBIT, 8'hAA, LINE_LOW, 0, 1'b0, RESET_TICKS);

        // Random commands, half of them whole bytes, until the run reaches its size.
        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                op = OP_WBIT;
            end else if (r < 40) begin
                op = OP_RBIT;
            end else if (r < 65) begin
                op = OP_WBYTE;
            end else if (r < 90) begin
                op = OP_RBYTE;
            end else begin
                op = OP_RESET;
            end
            sender_steady = ($urandom_range(0, 3) == 0);
            run_sequence(op, 8'($urandom), $urandom_range(LINE_RANDOM, LINE_HIGH),
                         $urandom_range(0, 4), ($urandom_range(0, 9) == 0),
                         TOTAL_ITEMS - items_sent);
            repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom), 1'($urandom));
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/owbm_pkg.sv
rtl/core/owbm_in_if.sv
rtl/core/owbm_out_if.sv
rtl/core/owbm_seq.sv
rtl/core/owbm_out_reg.sv
rtl/core/onewire_bus_master_unit.sv
tb/onewire_bus_checker.sv
tb/tb_onewire_bus_master_unit.sv
